/* hw/rtl/bsgd_pkg.sv */
package bsgd_pkg;

  localparam int FRAC_BITS      = 20;
  localparam int RES_BITS       = 24;
  localparam int SUM_BITS       = 48;
  localparam int CNT_BITS       = 32;
  localparam int MEAN_BITS      = 23;
  localparam int RATE_BITS      = 20;
  localparam int DECAY_BITS     = 16;
  localparam int CFG_DATA_BITS  = 23;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [2:0] MODE_TRAIN       = 3'd0;
  localparam logic [2:0] MODE_SCORE_TRAIN = 3'd1;
  localparam logic [2:0] MODE_SCORE_PROBE = 3'd2;
  localparam logic [2:0] MODE_SNAPSHOT    = 3'd3;
  localparam logic [2:0] MODE_END_EPOCH   = 3'd4;
  localparam logic [2:0] MODE_RESTORE     = 3'd5;
  localparam logic [2:0] MODE_CLEAR       = 3'd6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MEAN_RATING     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARN_RATE_INIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REG_WEIGHT      = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_DECAY      = 2'd3;

  localparam logic [MEAN_BITS-1:0]  MEAN_RATING_RESET     = 23'd3778338;
  localparam logic [RATE_BITS-1:0]  LEARN_RATE_INIT_RESET = 20'd11639;
  localparam logic [RATE_BITS-1:0]  REG_WEIGHT_RESET      = 20'd47186;
  localparam logic [DECAY_BITS-1:0] RATE_DECAY_RESET      = 16'd58982;

  typedef enum logic [1:0] {
    SWEEP_CLEAR,
    SWEEP_SAVE,
    SWEEP_RESTORE
  } sweep_op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] user_index;
    logic [14:0] item_index;
    logic [3:0]  rating;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] residual;
    logic [SUM_BITS-1:0]        train_sse;
    logic [SUM_BITS-1:0]        probe_sse;
    logic [CNT_BITS-1:0]        train_count;
    logic [CNT_BITS-1:0]        probe_count;
  } out_word_t;

  typedef struct packed {
    logic      load;
    logic      resid;
    logic      mul;
    logic      fin;
    logic      sweep_init;
    logic      sweep_run;
    sweep_op_t sweep_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       saved_valid;
    logic       sweep_last;
  } dp_status_t;

endpackage

/* hw/rtl/bsgd_table.sv */
module bsgd_table #(
  parameter int ROWS  = 65536,
  parameter int WIDTH = 24
) (
  input  logic                    clk,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [$clog2(ROWS)-1:0] saved_raddr,
  output logic [WIDTH-1:0]        saved_rdata,
  input  logic                    saved_we,
  input  logic [$clog2(ROWS)-1:0] saved_waddr,
  input  logic [WIDTH-1:0]        saved_wdata
);

  logic [WIDTH-1:0] live_mem [ROWS];
  logic [WIDTH-1:0] saved_mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      live_mem[waddr] <= wdata;
    end
    rdata <= live_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (saved_we) begin
      saved_mem[saved_waddr] <= saved_wdata;
    end
    saved_rdata <= saved_mem[saved_raddr];
  end

endmodule

/* hw/rtl/bsgd_datapath.sv */
module bsgd_datapath #(
  parameter int USER_ROWS = 65536,
  parameter int ITEM_ROWS = 32768,
  parameter int BIAS_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsgd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bsgd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  bsgd_pkg::in_word_t                  in_data,
  input  bsgd_pkg::ctrl_cmd_t                 cmd,
  output bsgd_pkg::dp_status_t                status,
  output bsgd_pkg::out_word_t                 out_data
);
  import bsgd_pkg::*;

  localparam int UAW      = $clog2(USER_ROWS);
  localparam int IAW      = $clog2(ITEM_ROWS);
  localparam int MAX_ROWS = (USER_ROWS > ITEM_ROWS) ? USER_ROWS : ITEM_ROWS;
  localparam int PTRW     = $clog2(MAX_ROWS + 1);
  localparam int B        = BIAS_BITS;
  localparam int EW       = 40;
  localparam int PWW      = B + RATE_BITS + 1;
  localparam int TW       = B + 3;
  localparam int PLW      = TW + RATE_BITS + 1;
  localparam int NW       = TW + 2;
  localparam int SQW      = 2 * RES_BITS;
  localparam int LPW      = RATE_BITS + DECAY_BITS + 1;

  localparam logic signed [PWW-1:0] HALF_PW = PWW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PLW-1:0] HALF_PL = PLW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SQW-1:0] HALF_SQ = SQW'(1) << (FRAC_BITS - 1);
  localparam logic [LPW-1:0]        HALF_LP = LPW'(1) << (DECAY_BITS - 1);
  localparam logic signed [EW-1:0]  RES_MAX_W = (EW'(1) << (RES_BITS - 1)) - EW'(1);
  localparam logic signed [EW-1:0]  RES_MIN_W = -RES_MAX_W - EW'(1);
  localparam logic signed [NW-1:0]  BIAS_MAX_N = (NW'(1) << (B - 1)) - NW'(1);
  localparam logic signed [NW-1:0]  BIAS_MIN_N = -BIAS_MAX_N - NW'(1);

  in_word_t in_reg;
  logic [31:0] u_ext, i_ext, ptr_ext;
  logic u_ok, m_ok, ptr_u_ok, ptr_i_ok;
  logic [UAW-1:0] u_addr, ptr_u_addr, cp_u_addr;
  logic [IAW-1:0] i_addr, ptr_i_addr, cp_i_addr;

  logic [MEAN_BITS-1:0]  mean_rating;
  logic [RATE_BITS-1:0]  learn_rate_init, reg_weight, learn_rate;
  logic [DECAY_BITS-1:0] rate_decay;
  logic [SUM_BITS-1:0]   train_sum, probe_sum;
  logic [CNT_BITS-1:0]   train_seen, probe_seen;
  logic                  saved_valid;

  sweep_op_t      sweep_op;
  logic [PTRW-1:0] ptr;
  logic           cp_u_we, cp_i_we;

  logic [UAW-1:0] u_raddr, u_waddr;
  logic [IAW-1:0] i_raddr, i_waddr;
  logic [B-1:0]   u_rdata, us_rdata, u_wdata, i_rdata, is_rdata, i_wdata;
  logic           u_we, us_we, i_we, is_we;

  logic signed [B-1:0]        ub, ib, ub_reg, ib_reg, nb_u, nb_i;
  logic signed [EW-1:0]       rat_w, gm_w, e_w;
  logic signed [RES_BITS-1:0] e_next, e_reg;
  logic signed [RATE_BITS:0]  rw_s, lr_s;
  logic signed [PWW-1:0]      pw_u, pw_i, rb_u, rb_i;
  logic signed [TW-1:0]       t_u, t_i;
  logic signed [PLW-1:0]      pl_u, pl_i, st_u, st_i;
  logic signed [NW-1:0]       nbs_u, nbs_i;
  logic signed [SQW-1:0]      sq_reg, sq_rnd;
  logic [SUM_BITS-1:0]        sq_val, ts_n, ps_n;
  logic [SUM_BITS:0]          ts_add, ps_add;
  logic [CNT_BITS-1:0]        tc_n, pc_n, tc_inc, pc_inc;
  logic [LPW-1:0]             lr_prod;
  logic                       is_train, is_score;

  // addresses and range checks
  assign u_ext      = 32'(in_reg.user_index);
  assign i_ext      = 32'(in_reg.item_index);
  assign ptr_ext    = 32'(ptr);
  assign u_ok       = u_ext < 32'(USER_ROWS);
  assign m_ok       = i_ext < 32'(ITEM_ROWS);
  assign ptr_u_ok   = ptr_ext < 32'(USER_ROWS);
  assign ptr_i_ok   = ptr_ext < 32'(ITEM_ROWS);
  assign u_addr     = u_ext[UAW-1:0];
  assign i_addr     = i_ext[IAW-1:0];
  assign ptr_u_addr = ptr_ext[UAW-1:0];
  assign ptr_i_addr = ptr_ext[IAW-1:0];

  assign is_train = in_reg.mode == MODE_TRAIN;
  assign is_score = in_reg.mode <= MODE_SCORE_PROBE;

  assign status.mode        = in_reg.mode;
  assign status.saved_valid = saved_valid;
  assign status.sweep_last  = ptr == PTRW'(MAX_ROWS);

  // table ports
  assign u_raddr = cmd.sweep_run ? ptr_u_addr : u_addr;
  assign i_raddr = cmd.sweep_run ? ptr_i_addr : i_addr;
  assign us_we   = cp_u_we && sweep_op == SWEEP_SAVE;
  assign is_we   = cp_i_we && sweep_op == SWEEP_SAVE;

  always_comb begin
    priority if (cp_u_we && sweep_op == SWEEP_RESTORE) begin
      u_we    = 1'b1;
      u_waddr = cp_u_addr;
      u_wdata = us_rdata;
    end else if (cmd.sweep_run && sweep_op == SWEEP_CLEAR) begin
      u_we    = ptr_u_ok;
      u_waddr = ptr_u_addr;
      u_wdata = '0;
    end else begin
      u_we    = cmd.fin && is_train && u_ok;
      u_waddr = u_addr;
      u_wdata = nb_u;
    end
  end

  always_comb begin
    priority if (cp_i_we && sweep_op == SWEEP_RESTORE) begin
      i_we    = 1'b1;
      i_waddr = cp_i_addr;
      i_wdata = is_rdata;
    end else if (cmd.sweep_run && sweep_op == SWEEP_CLEAR) begin
      i_we    = ptr_i_ok;
      i_waddr = ptr_i_addr;
      i_wdata = '0;
    end else begin
      i_we    = cmd.fin && is_train && m_ok;
      i_waddr = i_addr;
      i_wdata = nb_i;
    end
  end

  bsgd_table #(.ROWS(USER_ROWS), .WIDTH(B)) u_user_table (
    .clk         (clk),
    .raddr       (u_raddr),
    .rdata       (u_rdata),
    .we          (u_we),
    .waddr       (u_waddr),
    .wdata       (u_wdata),
    .saved_raddr (ptr_u_addr),
    .saved_rdata (us_rdata),
    .saved_we    (us_we),
    .saved_waddr (cp_u_addr),
    .saved_wdata (u_rdata)
  );

  bsgd_table #(.ROWS(ITEM_ROWS), .WIDTH(B)) u_item_table (
    .clk         (clk),
    .raddr       (i_raddr),
    .rdata       (i_rdata),
    .we          (i_we),
    .waddr       (i_waddr),
    .wdata       (i_wdata),
    .saved_raddr (ptr_i_addr),
    .saved_rdata (is_rdata),
    .saved_we    (is_we),
    .saved_waddr (cp_i_addr),
    .saved_wdata (i_rdata)
  );

  // residual
  assign ub    = u_ok ? signed'(u_rdata) : '0;
  assign ib    = m_ok ? signed'(i_rdata) : '0;
  assign rat_w = signed'(EW'({in_reg.rating, {FRAC_BITS{1'b0}}}));
  assign gm_w  = signed'(EW'(mean_rating));
  assign e_w   = rat_w - gm_w - EW'(ub) - EW'(ib);
  assign e_next = (e_w > RES_MAX_W) ? RES_BITS'(RES_MAX_W) :
                  (e_w < RES_MIN_W) ? RES_BITS'(RES_MIN_W) : RES_BITS'(e_w);

  assign rw_s = signed'({1'b0, reg_weight});
  assign lr_s = signed'({1'b0, learn_rate});

  // bias update
  assign rb_u  = (pw_u + HALF_PW) >>> FRAC_BITS;
  assign rb_i  = (pw_i + HALF_PW) >>> FRAC_BITS;
  assign t_u   = TW'(e_reg) - TW'(rb_u);
  assign t_i   = TW'(e_reg) - TW'(rb_i);
  assign st_u  = (pl_u + HALF_PL) >>> FRAC_BITS;
  assign st_i  = (pl_i + HALF_PL) >>> FRAC_BITS;
  assign nbs_u = NW'(ub_reg) + NW'(st_u);
  assign nbs_i = NW'(ib_reg) + NW'(st_i);
  assign nb_u  = (nbs_u > BIAS_MAX_N) ? B'(BIAS_MAX_N) :
                 (nbs_u < BIAS_MIN_N) ? B'(BIAS_MIN_N) : B'(nbs_u);
  assign nb_i  = (nbs_i > BIAS_MAX_N) ? B'(BIAS_MAX_N) :
                 (nbs_i < BIAS_MIN_N) ? B'(BIAS_MIN_N) : B'(nbs_i);

  // error sums
  assign sq_rnd = (sq_reg + HALF_SQ) >>> FRAC_BITS;
  assign sq_val = SUM_BITS'(sq_rnd);
  assign ts_add = {1'b0, train_sum} + {1'b0, sq_val};
  assign ps_add = {1'b0, probe_sum} + {1'b0, sq_val};
  assign tc_inc = (&train_seen) ? train_seen : CNT_BITS'(train_seen + 1'b1);
  assign pc_inc = (&probe_seen) ? probe_seen : CNT_BITS'(probe_seen + 1'b1);
  assign lr_prod = LPW'(learn_rate) * LPW'(rate_decay) + HALF_LP;

  always_comb begin
    ts_n = train_sum;
    ps_n = probe_sum;
    tc_n = train_seen;
    pc_n = probe_seen;
    priority if (in_reg.mode == MODE_SCORE_TRAIN) begin
      ts_n = ts_add[SUM_BITS] ? '1 : ts_add[SUM_BITS-1:0];
      tc_n = tc_inc;
    end else if (in_reg.mode == MODE_SCORE_PROBE) begin
      ps_n = ps_add[SUM_BITS] ? '1 : ps_add[SUM_BITS-1:0];
      pc_n = pc_inc;
    end else if (in_reg.mode == MODE_CLEAR) begin
      ts_n = '0;
      ps_n = '0;
      tc_n = '0;
      pc_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_reg <= in_data;
    end
    if (cmd.resid) begin
      e_reg  <= e_next;
      ub_reg <= ub;
      ib_reg <= ib;
      pw_u   <= PWW'(ub) * PWW'(rw_s);
      pw_i   <= PWW'(ib) * PWW'(rw_s);
    end
    if (cmd.mul) begin
      pl_u   <= PLW'(t_u) * PLW'(lr_s);
      pl_i   <= PLW'(t_i) * PLW'(lr_s);
      sq_reg <= SQW'(e_reg) * SQW'(e_reg);
    end
    if (cmd.fin) begin
      out_data.residual <= is_score ? e_reg : '0;
      if (in_reg.mode == MODE_END_EPOCH) begin
        out_data.train_sse   <= train_sum;
        out_data.probe_sse   <= probe_sum;
        out_data.train_count <= train_seen;
        out_data.probe_count <= probe_seen;
      end else begin
        out_data.train_sse   <= ts_n;
        out_data.probe_sse   <= ps_n;
        out_data.train_count <= tc_n;
        out_data.probe_count <= pc_n;
      end
    end
    cp_u_addr <= ptr_u_addr;
    cp_i_addr <= ptr_i_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_rating     <= MEAN_RATING_RESET;
      learn_rate_init <= LEARN_RATE_INIT_RESET;
      reg_weight      <= REG_WEIGHT_RESET;
      rate_decay      <= RATE_DECAY_RESET;
      learn_rate      <= LEARN_RATE_INIT_RESET;
      train_sum       <= '0;
      probe_sum       <= '0;
      train_seen      <= '0;
      probe_seen      <= '0;
      saved_valid     <= 1'b0;
      sweep_op        <= SWEEP_CLEAR;
      ptr             <= '0;
      cp_u_we         <= 1'b0;
      cp_i_we         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEAN_RATING:     mean_rating     <= cfg_data[MEAN_BITS-1:0];
          CFG_LEARN_RATE_INIT: learn_rate_init <= cfg_data[RATE_BITS-1:0];
          CFG_REG_WEIGHT:      reg_weight      <= cfg_data[RATE_BITS-1:0];
          CFG_RATE_DECAY:      rate_decay      <= cfg_data[DECAY_BITS-1:0];
        endcase
      end
      if (cmd.fin) begin
        if (in_reg.mode == MODE_END_EPOCH) begin
          train_sum  <= '0;
          probe_sum  <= '0;
          train_seen <= '0;
          probe_seen <= '0;
          learn_rate <= lr_prod[DECAY_BITS +: RATE_BITS];
        end else begin
          train_sum  <= ts_n;
          probe_sum  <= ps_n;
          train_seen <= tc_n;
          probe_seen <= pc_n;
        end
        if (in_reg.mode == MODE_CLEAR) begin
          learn_rate <= learn_rate_init;
        end
        if (in_reg.mode == MODE_SNAPSHOT) begin
          saved_valid <= 1'b1;
        end
      end
      if (cmd.sweep_init) begin
        sweep_op <= cmd.sweep_op;
        ptr      <= '0;
      end else if (cmd.sweep_run) begin
        ptr <= status.sweep_last ? '0 : PTRW'(ptr + 1'b1);
      end
      cp_u_we <= cmd.sweep_run && sweep_op != SWEEP_CLEAR && ptr_u_ok;
      cp_i_we <= cmd.sweep_run && sweep_op != SWEEP_CLEAR && ptr_i_ok;
    end
  end

endmodule

/* hw/rtl/bsgd_ctrl.sv */
module bsgd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic                 out_ready,
  output logic                 out_valid,
  output bsgd_pkg::ctrl_cmd_t  cmd,
  input  bsgd_pkg::dp_status_t status
);
  import bsgd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RESID,
    S_MUL,
    S_FIN,
    S_SWEEP
  } state_t;

  state_t state;
  logic   out_free;
  logic   need_sweep;

  assign out_free   = !out_valid || out_ready;
  assign need_sweep = status.mode == MODE_SNAPSHOT || status.mode == MODE_CLEAR ||
                      (status.mode == MODE_RESTORE && status.saved_valid);
  assign in_ready   = state == S_IDLE;

  always_comb begin
    cmd.load       = state == S_IDLE && in_valid;
    cmd.resid      = state == S_RESID;
    cmd.mul        = state == S_MUL;
    cmd.fin        = state == S_FIN && out_free;
    cmd.sweep_init = cmd.fin && need_sweep;
    cmd.sweep_run  = state == S_SWEEP;
    priority if (status.mode == MODE_SNAPSHOT) begin
      cmd.sweep_op = SWEEP_SAVE;
    end else if (status.mode == MODE_RESTORE) begin
      cmd.sweep_op = SWEEP_RESTORE;
    end else begin
      cmd.sweep_op = SWEEP_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_mode <= MODE_SCORE_PROBE) ? S_READ : S_FIN;
          end
        end
        S_READ:  state <= S_RESID;
        S_RESID: state <= S_MUL;
        S_MUL:   state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= need_sweep ? S_SWEEP : S_IDLE;
          end
        end
        S_SWEEP: begin
          if (status.sweep_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && status.sweep_last) |=> (state == S_IDLE))
    else $error("sweep did not end");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.resid, cmd.mul, cmd.fin, cmd.sweep_run}))
    else $error("conflicting datapath commands");
`endif

endmodule

/* hw/rtl/bias_sgd_trainer.sv */
// Bias trainer for a baseline rating predictor: a user bias table and an item bias table,
// updated by SGD on train words and scored on score words, with snapshot, restore, clear
// and end-of-epoch control words. Train and score words go through accept, registered table
// read, residual, multiply and write back before the next acceptance, and write back waits
// until the last result is taken; other words go from accept to write back. Snapshot, valid
// restore and clear then sweep the tables one row a cycle over row pointers 0 through
// max(USER_ROWS, ITEM_ROWS); the same clearing pass runs after reset, and no word is
// accepted during a sweep. Configuration writes are taken at any time.
module bias_sgd_trainer #(
  parameter int USER_ROWS = 65536,
  parameter int ITEM_ROWS = 32768,
  parameter int BIAS_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsgd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bsgd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bsgd_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bsgd_pkg::out_word_t                 out_data
);
  import bsgd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  bsgd_datapath #(
    .USER_ROWS (USER_ROWS),
    .ITEM_ROWS (ITEM_ROWS),
    .BIAS_BITS (BIAS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
